// File: rtl/tpsp_pkg.sv
// shared types and constants of the touch panel serial protocol unit
`default_nettype none
package tpsp_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned CmdW      = 2;
  localparam int unsigned MaskW     = 35;
  localparam int unsigned GroupW    = 5;
  localparam int unsigned NumGroups = 7;
  localparam int unsigned CmdLen    = 4;
  localparam int unsigned BufDepth  = 5;
  localparam int unsigned CntW      = 3;
  localparam int unsigned IdxW      = 4;
  localparam int unsigned JobDataW  = 40;
  localparam int unsigned AddrW     = 3;
  localparam int unsigned DataW     = 32;
  localparam int unsigned QueueDepth = 2;

  // command selectors and framing bytes
  localparam logic [ByteW-1:0] SelReset   = 8'h45;
  localparam logic [ByteW-1:0] SelHalt    = 8'h4C;
  localparam logic [ByteW-1:0] SelStat    = 8'h41;
  localparam logic [ByteW-1:0] SelRatio   = 8'h72;
  localparam logic [ByteW-1:0] SelSens    = 8'h6B;
  localparam logic [ByteW-1:0] ByteOpen   = 8'h7B;
  localparam logic [ByteW-1:0] ByteClose  = 8'h7D;
  localparam logic [ByteW-1:0] FrameOpen  = 8'h28;
  localparam logic [ByteW-1:0] FrameClose = 8'h29;

  localparam logic [ByteW-1:0] PeriodReset = 8'd4;
  localparam logic [AddrW-1:0] AddrPeriod  = 3'd0;

  // byte index of the closing byte in each frame kind
  localparam logic [IdxW-1:0] EchoLastIdx   = IdxW'(CmdLen + 1);
  localparam logic [IdxW-1:0] ReportLastIdx = IdxW'(NumGroups + 1);

  typedef enum logic [CmdW-1:0] {
    CmdRx    = 2'd0,
    CmdTick  = 2'd1,
    CmdTouch = 2'd2
  } cmd_e;

  typedef enum logic {
    JobEcho   = 1'b0,
    JobReport = 1'b1
  } job_e;

  typedef struct packed {
    job_e                kind;
    logic [JobDataW-1:0] data;
  } job_t;

endpackage
`default_nettype wire

// File: rtl/tpsp_if.sv
// input and output channel interfaces
`default_nettype none
interface tpsp_in_if;
  logic                        valid;
  logic                        ready;
  logic [tpsp_pkg::CmdW-1:0]   command;
  logic [tpsp_pkg::ByteW-1:0]  rx_byte;
  logic [tpsp_pkg::MaskW-1:0]  touch_state;

  modport source (output valid, command, rx_byte, touch_state, input ready);
  modport sink   (input valid, command, rx_byte, touch_state, output ready);
endinterface

interface tpsp_out_if;
  logic                        valid;
  logic                        ready;
  logic [tpsp_pkg::ByteW-1:0]  tx_byte;
  logic                        last;

  modport source (output valid, tx_byte, last, input ready);
  modport sink   (input valid, tx_byte, last, output ready);
endinterface
`default_nettype wire

// File: rtl/tpsp_front.sv
// front end: deframes commands, keeps touch and report state, issues frame jobs
`default_nettype none
module tpsp_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  tpsp_in_if.sink                         in_if,
  input  wire logic [tpsp_pkg::ByteW-1:0] report_period_i,
  input  wire logic                       full_i,
  output      logic                       push_o,
  output      tpsp_pkg::job_t             job_o
);
  import tpsp_pkg::*;

  logic [MaskW-1:0] touch_mask_q, touch_mask_d;
  logic             reporting_q, reporting_d;
  logic [ByteW-1:0] ticks_left_q, ticks_left_d;
  logic [CntW-1:0]  cmd_count_q, cmd_count_d;
  logic [ByteW-1:0] cmd_buf_q [BufDepth];
  logic             buf_we;
  logic             accept;
  logic             echo;
  logic             report;
  logic             known;
  logic [ByteW-1:0] period_eff;

  assign in_if.ready = !full_i;
  assign accept      = in_if.valid && in_if.ready;
  assign period_eff  = (report_period_i == '0) ? ByteW'(1) : report_period_i;

  always_comb begin
    touch_mask_d = touch_mask_q;
    reporting_d  = reporting_q;
    ticks_left_d = ticks_left_q;
    cmd_count_d  = cmd_count_q;
    buf_we       = 1'b0;
    echo         = 1'b0;
    known        = 1'b1;
    unique case (cmd_e'(in_if.command))
      CmdRx: begin
        if (in_if.rx_byte == ByteOpen) begin
          cmd_count_d = '0;
        end else if (in_if.rx_byte == ByteClose) begin
          if (cmd_count_q == CntW'(CmdLen)) begin
            unique case (cmd_buf_q[2])
              SelReset: begin
                touch_mask_d = '0;
                reporting_d  = 1'b0;
              end
              SelHalt:  reporting_d = 1'b0;
              SelStat:  reporting_d = 1'b1;
              SelRatio, SelSens: echo = 1'b1;
              default: ;
            endcase
            cmd_count_d = '0;
          end
        end else if (cmd_count_q < CntW'(BufDepth)) begin
          buf_we      = 1'b1;
          cmd_count_d = cmd_count_q + CntW'(1);
        end
      end
      CmdTick: begin
        if (ticks_left_q != '0) begin
          ticks_left_d = ticks_left_q - ByteW'(1);
        end
      end
      CmdTouch: touch_mask_d = in_if.touch_state;
      default:  known = 1'b0;
    endcase
    report = known && reporting_d && (ticks_left_d == '0);
    if (report) begin
      ticks_left_d = period_eff;
    end
  end

  // one job per item at most: echo never coincides with a due report
  assign push_o = accept && (echo || report);
  always_comb begin
    if (report) begin
      job_o.kind = JobReport;
      job_o.data = JobDataW'(touch_mask_d);
    end else begin
      job_o.kind = JobEcho;
      job_o.data = JobDataW'({cmd_buf_q[3], cmd_buf_q[2], cmd_buf_q[1], cmd_buf_q[0]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      touch_mask_q <= '0;
      reporting_q  <= 1'b0;
      ticks_left_q <= '0;
      cmd_count_q  <= '0;
    end else if (accept) begin
      touch_mask_q <= touch_mask_d;
      reporting_q  <= reporting_d;
      ticks_left_q <= ticks_left_d;
      cmd_count_q  <= cmd_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && buf_we) begin
      cmd_buf_q[cmd_count_q] <= in_if.rx_byte;
    end
  end

endmodule
`default_nettype wire

// File: rtl/tpsp_queue.sv
// two-entry job queue between front and back
`default_nettype none
module tpsp_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire tpsp_pkg::job_t job_i,
  input  wire logic           pop_i,
  output      logic           full_o,
  output      logic           empty_o,
  output      tpsp_pkg::job_t head_o
);
  import tpsp_pkg::*;

  job_t       mem_q [QueueDepth];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule
`default_nettype wire

// File: rtl/tpsp_back.sv
// back end: serializes echo and report jobs into bytes
`default_nettype none
module tpsp_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           empty_i,
  input  wire tpsp_pkg::job_t head_i,
  output      logic           pop_o,
  tpsp_out_if.source          out_if
);
  import tpsp_pkg::*;

  logic [IdxW-1:0]  idx_q;
  logic             out_valid_q;
  logic [ByteW-1:0] tx_q;
  logic             last_q;
  logic             load;
  logic             is_last;
  logic [ByteW-1:0] byte_d;
  logic [IdxW-1:0]  pos;

  assign load    = !empty_i && (!out_valid_q || out_if.ready);
  assign is_last = (head_i.kind == JobEcho) ? (idx_q == EchoLastIdx)
                                            : (idx_q == ReportLastIdx);
  assign pop_o   = load && is_last;
  assign pos     = idx_q - IdxW'(1);

  always_comb begin
    if (idx_q == '0) begin
      byte_d = FrameOpen;
    end else if (is_last) begin
      byte_d = FrameClose;
    end else if (head_i.kind == JobEcho) begin
      byte_d = head_i.data[pos[1:0]*ByteW +: ByteW];
    end else begin
      byte_d = ByteW'(head_i.data[pos[2:0]*GroupW +: GroupW]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q       <= is_last ? '0 : idx_q + IdxW'(1);
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tx_q   <= byte_d;
      last_q <= is_last;
    end
  end

  assign out_if.valid   = out_valid_q;
  assign out_if.tx_byte = tx_q;
  assign out_if.last    = last_q;

endmodule
`default_nettype wire

// File: rtl/touch_panel_serial_protocol_unit.sv
// top level of the touch panel serial protocol unit
//
//   channel   dir   handshake        payload
//   in_i      in    valid/ready      command, rx_byte, touch_state
//   out_o     out   valid/ready      tx_byte, last
//   apb       in    psel/penable     report_period at address 0
//
// the front takes one item per cycle while the queue has room and settles all protocol state in that cycle
// a frame job (6-byte echo or 9-byte report) goes into a two-entry queue
// the back sends one byte per cycle while the receiver is ready, from the queue head into an output register
// in_i stalls only while the queue holds two unfinished frames
// reset clears all control state at once; the command buffer is never cleared
`default_nettype none
module touch_panel_serial_protocol_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  tpsp_in_if.sink                             in_i,
  tpsp_out_if.source                          out_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [tpsp_pkg::AddrW-1:0]     paddr,
  input  wire logic [tpsp_pkg::DataW-1:0]     pwdata,
  output      logic [tpsp_pkg::DataW-1:0]     prdata,
  output      logic                           pready
);
  import tpsp_pkg::*;

  logic [ByteW-1:0] report_period_q;
  logic             cfg_we;
  logic             push;
  logic             pop;
  logic             full;
  logic             empty;
  job_t             job;
  job_t             head;

  // configuration register, written in the apb access phase
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == AddrPeriod);
  assign prdata = (paddr == AddrPeriod) ? DataW'(report_period_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      report_period_q <= PeriodReset;
    end else if (cfg_we) begin
      report_period_q <= pwdata[ByteW-1:0];
    end
  end

  // front: deframing, command dispatch, tick timer
  tpsp_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_if           (in_i),
    .report_period_i (report_period_q),
    .full_i          (full),
    .push_o          (push),
    .job_o           (job)
  );

  // decoupling queue of frame jobs
  tpsp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  // back: byte serializer
  tpsp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_if  (out_o)
  );

  // front only takes items while the queue has room
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready == !full)
    else $error("input ready disagrees with queue state");

  // a job is never pushed into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && full))
    else $error("job pushed into full queue");

  // the final byte of every frame is the closing parenthesis
  a_last_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.last) |-> (out_o.tx_byte == FrameClose))
    else $error("frame ends on a wrong byte");

  // after a frame's last transfer with data waiting, the next byte opens a frame
  a_open_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.last) |=>
      (!out_o.valid || out_o.tx_byte == FrameOpen))
    else $error("frame does not start with opening parenthesis");

endmodule
`default_nettype wire

// File: tb/tb.sv
// self-checking testbench of the touch panel serial protocol unit with random traffic and stalls
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tpsp_pkg::*;

  // quiet cycles with no transfer on either channel before the run is declared hung
  localparam int unsigned QuietLimit   = 4000;
  // cycles allowed for the frame queue and output register to go quiet
  localparam int unsigned SettleCycles = 20;
  // length of the deliberate receiver hold-off
  localparam int unsigned HoldCycles   = 250;
  // the one command code that the block ignores
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;

  // expected transmit bytes, predicted from the accepted input items
  class tx_byte_scoreboard;
    typedef struct packed {
      logic [ByteW-1:0] tx_byte;
      logic             last;
    } tx_beat_t;

    tx_beat_t         tx_bytes_due[$];
    logic [ByteW-1:0] period;
    logic [ByteW-1:0] ticks_left;
    logic [MaskW-1:0] touch_mask;
    bit               reporting;
    logic [ByteW-1:0] cmd_bytes[BufDepth];
    int unsigned      cmd_count;
    int unsigned      errors, n_in, n_out, n_echo, n_report;

    function new();
      period     = PeriodReset;
      ticks_left = '0;
      touch_mask = '0;
      reporting  = 1'b0;
      cmd_count  = 0;
      errors     = 0;
      n_in       = 0;
      n_out      = 0;
      n_echo     = 0;
      n_report   = 0;
    endfunction

    function void due(logic [ByteW-1:0] b, logic last);
      tx_beat_t beat;
      beat.tx_byte = b;
      beat.last    = last;
      tx_bytes_due.push_back(beat);
    endfunction

    // closing brace: act on the held command if exactly four bytes are held
    function void run_command();
      if (cmd_count != CmdLen) return;
      case (cmd_bytes[2])
        SelReset: begin
          touch_mask = '0;
          reporting  = 1'b0;
        end
        SelHalt: reporting = 1'b0;
        SelStat: reporting = 1'b1;
        SelRatio, SelSens: begin
          due(FrameOpen, 1'b0);
          for (int i = 0; i < CmdLen; i++) due(cmd_bytes[i], 1'b0);
          due(FrameClose, 1'b1);
          n_echo++;
        end
        default: ;
      endcase
      cmd_count = 0;
    endfunction

    function void note_transfer_in(logic [CmdW-1:0] command, logic [ByteW-1:0] rx,
                                   logic [MaskW-1:0] ts);
      n_in++;
      if (command == CmdRx) begin
        if (rx == ByteOpen) begin
          cmd_count = 0;
        end else if (rx == ByteClose) begin
          run_command();
        end else if (cmd_count < BufDepth) begin
          cmd_bytes[cmd_count] = rx;
          cmd_count++;
        end
      end else if (command == CmdTick) begin
        if (ticks_left != '0) ticks_left--;
      end else if (command == CmdTouch) begin
        touch_mask = ts;
      end else begin
        return;
      end
      if (reporting && ticks_left == '0) begin
        due(FrameOpen, 1'b0);
        for (int g = 0; g < NumGroups; g++) begin
          due(ByteW'(touch_mask[g*GroupW +: GroupW]), 1'b0);
        end
        due(FrameClose, 1'b1);
        ticks_left = (period == '0) ? 8'd1 : period;
        n_report++;
      end
    endfunction

    function void check_transfer_out(logic [ByteW-1:0] tx, logic last);
      tx_beat_t want;
      n_out++;
      if (tx_bytes_due.size() == 0) begin
        $error("unexpected output transfer: tx_byte %h last %b", tx, last);
        errors++;
        return;
      end
      want = tx_bytes_due.pop_front();
      if (tx !== want.tx_byte) begin
        $error("tx_byte: expected %h, got %h", want.tx_byte, tx);
        errors++;
      end
      if (last !== want.last) begin
        $error("last: expected %b, got %b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i  = 1'b0;
  logic             rst_ni = 1'b0;
  logic             psel, penable, pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  tpsp_in_if  in_ch ();
  tpsp_out_if out_ch ();

  touch_panel_serial_protocol_unit uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk_i = ~clk_i;

  tx_byte_scoreboard sb;
  bit                idle_on;        // random gaps and stalls on both channels
  bit                long_hold_req;  // asks the receiver for one long hold-off
  int unsigned       quiet_cycles;
  int unsigned       n_settings;

  // monitor: every transfer is sampled at the rising edge, input first so a
  // result can never be checked ahead of the item that caused it
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note_transfer_in(in_ch.command, in_ch.rx_byte, in_ch.touch_state);
      end
      if (out_ch.valid && out_ch.ready) begin
        sb.check_transfer_out(out_ch.tx_byte, out_ch.last);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      // watchdog: nothing moved for far longer than any legal stall
      if (quiet_cycles >= QuietLimit) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // receiver: one ready update per edge, short and long stalls at random,
  // plus a long hold-off on request, counted here
  initial begin
    int unsigned stall_left, hold_left;
    stall_left = 0;
    hold_left  = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        hold_left     = HoldCycles;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (idle_on && $urandom_range(0, 3) == 0) begin
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 3);
        end
      end
    end
  end

  // sender gap: mostly none, often short, now and then long
  function automatic int unsigned tx_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [MaskW-1:0] rand_mask();
    return MaskW'({$urandom, $urandom});
  endfunction

  // touch masks with the extremes and single zones mixed in
  function automatic logic [MaskW-1:0] pick_mask();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return MaskW'(1) << $urandom_range(0, MaskW - 1);
      default: return rand_mask();
    endcase
  endfunction

  // any byte that is not a brace
  function automatic logic [ByteW-1:0] plain_byte();
    logic [ByteW-1:0] b;
    do b = ByteW'($urandom); while (b == ByteOpen || b == ByteClose);
    return b;
  endfunction

  function automatic logic [ByteW-1:0] pick_selector();
    case ($urandom_range(0, 9))
      0, 1, 2: return SelStat;
      3:       return SelReset;
      4, 5:    return SelHalt;
      6:       return SelRatio;
      7:       return SelSens;
      default: return plain_byte();  // mostly unknown selectors
    endcase
  endfunction

  // offer one item and return at the edge where it is accepted; valid stays
  // high unless a gap follows
  task automatic send_item(logic [CmdW-1:0] c, logic [ByteW-1:0] b, logic [MaskW-1:0] ts);
    int unsigned g;
    g = tx_gap();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= c;
    in_ch.rx_byte     <= b;
    in_ch.touch_state <= ts;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic send_rx(logic [ByteW-1:0] b);
    send_item(CmdRx, b, rand_mask());
  endtask

  // a well-formed command: open brace, four bytes with the selector third, close brace
  task automatic send_command(logic [ByteW-1:0] b0, logic [ByteW-1:0] b1,
                              logic [ByteW-1:0] sel, logic [ByteW-1:0] b3);
    send_rx(ByteOpen);
    send_rx(b0);
    send_rx(b1);
    send_rx(sel);
    send_rx(b3);
    send_rx(ByteClose);
  endtask

  // sender stops and waits for every expected byte to arrive
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.tx_bytes_due.size() != 0) @(posedge clk_i);
  endtask

  // drained, then a margin for frames still inside the block
  task automatic settle();
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [AddrW-1:0] a, logic [DataW-1:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read(logic [AddrW-1:0] a, output logic [DataW-1:0] d);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= a;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    d = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_period(logic [ByteW-1:0] v);
    logic [DataW-1:0] got;
    apb_read(AddrPeriod, got);
    if (got !== DataW'(v)) begin
      $error("report_period: expected %h, got %h", DataW'(v), got);
      sb.errors++;
    end
  endtask

  // only called while the block is idle
  task automatic set_period(logic [ByteW-1:0] v);
    apb_write(AddrPeriod, DataW'(v));
    sb.period = v;
    n_settings++;
    check_period(v);
  endtask

  task automatic directed_items();
    send_item(CmdUnused, 8'hFF, '1);  // ignored code
    send_item(CmdTouch, 8'h00, '1);   // every zone touched
    // stat with no ticks pending reports at once, all groups at 5'h1f
    send_command(8'h00, 8'hFF, SelStat, 8'h80);
    send_command(8'hFF, 8'h00, SelRatio, 8'h7F);
    // bad length keeps the count, so two more bytes complete a sens command
    send_rx(ByteOpen);
    send_rx(8'h11);
    send_rx(8'h22);
    send_rx(ByteClose);
    send_rx(SelSens);
    send_rx(8'h33);
    send_rx(ByteClose);
    send_command(8'h01, 8'h02, SelHalt, 8'h03);
    send_command(8'hFE, 8'hFD, SelReset, 8'h01);
  endtask

  // period 1: every tick reports, so holding the receiver fills the frame
  // queue and the input has to stall
  task automatic fill_under_hold();
    idle_on = 1'b0;
    send_command(plain_byte(), plain_byte(), SelStat, plain_byte());
    long_hold_req = 1'b1;
    repeat (12) send_item(CmdTick, ByteW'($urandom), rand_mask());
    wait_drained();
    idle_on = 1'b1;
  endtask

  // mostly well-formed commands and tick bursts, the rest touch updates, broken framing, noise and drains
  task automatic run_traffic(int unsigned n_items);
    int unsigned sent, r, len;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        send_command(plain_byte(), plain_byte(), pick_selector(), plain_byte());
        sent += 6;
      end else if (r < 72) begin
        len = $urandom_range(1, 6);
        repeat (len) send_item(CmdTick, ByteW'($urandom), rand_mask());
        sent += len;
      end else if (r < 82) begin
        send_item(CmdTouch, ByteW'($urandom), pick_mask());
        sent++;
      end else if (r < 95) begin
        // broken framing: open brace sometimes missing, zero to seven random bytes, braces inside
        if ($urandom_range(0, 3) != 0) begin
          send_rx(ByteOpen);
          sent++;
        end
        len = $urandom_range(0, 7);
        repeat (len) send_rx(ByteW'($urandom));
        send_rx(ByteClose);
        sent += len + 1;
      end else if (r < 98) begin
        send_item(CmdUnused, ByteW'($urandom), rand_mask());
        sent++;
      end else begin
        wait_drained();
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [ByteW-1:0] period_plan[$];
    sb            = new();
    idle_on       = 1'b1;
    long_hold_req = 1'b0;
    quiet_cycles  = 0;
    n_settings    = 0;
    in_ch.valid       <= 1'b0;
    in_ch.command     <= CmdRx;
    in_ch.rx_byte     <= '0;
    in_ch.touch_state <= '0;
    out_ch.ready      <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    check_period(PeriodReset);
    directed_items();

    // zero acts as one; then both extremes and a few ordinary periods
    period_plan = '{8'd0, 8'd1, 8'd255, ByteW'($urandom_range(2, 6)), 8'd3,
                    ByteW'($urandom_range(7, 20))};
    for (int k = 0; k < period_plan.size(); k++) begin
      settle();
      set_period(period_plan[k]);
      idle_on = (k != 3);  // one phase runs back to back on both sides
      if (period_plan[k] == 8'd1) fill_under_hold();
      run_traffic(52);
    end

    settle();
    if (sb.tx_bytes_due.size() != 0) begin
      $error("%0d expected output transfers never arrived", sb.tx_bytes_due.size());
      sb.errors++;
    end

    $display("tb: %0d input and %0d output transfers, %0d echo and %0d report frames",
             sb.n_in, sb.n_out, sb.n_echo, sb.n_report);
    $display("tb: %0d report_period settings incl. 0, 1 and 255, receiver hold-off, %0d errors",
             n_settings, sb.errors);
    if (sb.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
rtl/tpsp_pkg.sv
rtl/tpsp_if.sv
rtl/tpsp_front.sv
rtl/tpsp_queue.sv
rtl/tpsp_back.sv
rtl/touch_panel_serial_protocol_unit.sv
tb/tb.sv
